// ===== design/pinyin_tone_mark_to_number_assert.svh =====
// Assertion macros shared by the checker of the pinyin tone converter.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef PINYIN_TONE_MARK_TO_NUMBER_ASSERT_SVH
`define PINYIN_TONE_MARK_TO_NUMBER_ASSERT_SVH

// Assertion clocked on clk and switched off while the active-low reset is low.
`define PTMTN_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion clocked on clk that stays live through reset.
`define PTMTN_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ptmtn_pkg.sv =====
// Package of the pinyin tone converter: types, mode codes, the mark table.
// Depends on nothing; the front end, queue, back end and top level use it.
`timescale 1ns / 1ps

package ptmtn_pkg;

    // Tone mode register codes; the remaining code behaves as numbered.
    localparam logic [1:0] TONE_STRIP    = 2'd0;
    localparam logic [1:0] TONE_NUMBERED = 2'd1;
    localparam logic [1:0] TONE_MOVED    = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_MARKS       = 35;

    // One table entry. Byte k of from sits at [31-8k -: 8], of to at [23-8k -: 8].
    typedef struct packed {
        logic [2:0]  flen;
        logic [31:0] from;
        logic [1:0]  tlen;
        logic [23:0] to;
    } t_mark;

    typedef struct packed {
        logic        hit;
        logic        maybe;
        logic [2:0]  flen;
        logic [1:0]  tlen;
        logic [23:0] text;
    } t_match;

    // Converted text of one input byte, up to four bytes, first byte in [31:24].
    typedef struct packed {
        logic [31:0] text;
        logic [2:0]  cnt;
        logic        last;
    } t_tok;

    function automatic t_mark mk(input logic [2:0] fl, input logic [31:0] fr,
                                 input logic [1:0] tl, input logic [23:0] tt);
        t_mark m;
        m.flen = fl;
        m.from = fr;
        m.tlen = tl;
        m.to   = tt;
        return m;
    endfunction

    // Two-byte code point turning into a letter and a digit.
    function automatic t_mark mk2(input logic [15:0] cp, input logic [7:0] letter,
                                  input logic [7:0] digit);
        return mk(3'd2, {cp, 16'h0000}, 2'd2, {letter, digit, 8'h00});
    endfunction

    function automatic t_mark mark_entry(input logic [5:0] e);
        t_mark m;
        case (e)
            6'd0:    m = mk2(16'hC481, "a", "1");
            6'd1:    m = mk2(16'hC3A1, "a", "2");
            6'd2:    m = mk2(16'hC78E, "a", "3");
            6'd3:    m = mk2(16'hC3A0, "a", "4");
            6'd4:    m = mk2(16'hC493, "e", "1");
            6'd5:    m = mk2(16'hC3A9, "e", "2");
            6'd6:    m = mk2(16'hC49B, "e", "3");
            6'd7:    m = mk2(16'hC3A8, "e", "4");
            6'd8:    m = mk2(16'hC58D, "o", "1");
            6'd9:    m = mk2(16'hC3B3, "o", "2");
            6'd10:   m = mk2(16'hC792, "o", "3");
            6'd11:   m = mk2(16'hC3B2, "o", "4");
            6'd12:   m = mk2(16'hC4AB, "i", "1");
            6'd13:   m = mk2(16'hC3AD, "i", "2");
            6'd14:   m = mk2(16'hC790, "i", "3");
            6'd15:   m = mk2(16'hC3AC, "i", "4");
            6'd16:   m = mk2(16'hC5AB, "u", "1");
            6'd17:   m = mk2(16'hC3BA, "u", "2");
            6'd18:   m = mk2(16'hC794, "u", "3");
            6'd19:   m = mk2(16'hC3B9, "u", "4");
            6'd20:   m = mk(3'd2, 32'hC3BC_0000, 2'd1, {"v", 16'h0000});
            6'd21:   m = mk2(16'hC796, "v", "1");
            6'd22:   m = mk2(16'hC798, "v", "2");
            6'd23:   m = mk2(16'hC79A, "v", "3");
            6'd24:   m = mk2(16'hC79C, "v", "4");
            6'd25:   m = mk2(16'hC584, "n", "2");
            6'd26:   m = mk2(16'hC588, "n", "3");
            6'd27:   m = mk2(16'hC7B9, "n", "4");
            6'd28:   m = mk(3'd3, 32'h6DCC_8400, 2'd2, {"m", "1", 8'h00});
            6'd29:   m = mk(3'd3, 32'hE1B8_BF00, 2'd2, {"m", "2", 8'h00});
            6'd30:   m = mk(3'd3, 32'h6DCC_8000, 2'd2, {"m", "4", 8'h00});
            6'd31:   m = mk(3'd4, 32'hC3AA_CC84, 2'd3, {8'hC3, 8'hAA, "1"});
            6'd32:   m = mk(3'd3, 32'hE1BA_BF00, 2'd3, {8'hC3, 8'hAA, "2"});
            6'd33:   m = mk(3'd4, 32'hC3AA_CC8C, 2'd3, {8'hC3, 8'hAA, "3"});
            6'd34:   m = mk(3'd3, 32'hE1BB_8100, 2'd3, {8'hC3, 8'hAA, "4"});
            default: m = '0;
        endcase
        return m;
    endfunction

    // Compares the rem bytes at the top of win with every entry. A hit needs the
    // whole entry inside the window; maybe means the window is a proper prefix.
    function automatic t_match match_window(input logic [31:0] win, input logic [2:0] rem);
        t_match r;
        t_mark  m;
        logic   eq;
        r = '0;
        for (int e = 0; e < NUM_MARKS; e++) begin
            m  = mark_entry(6'(e));
            eq = 1'b1;
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < m.flen && 3'(k) < rem &&
                    win[31-8*k -: 8] != m.from[31-8*k -: 8]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                if (m.flen <= rem) begin
                    if (!r.hit) begin
                        r.hit  = 1'b1;
                        r.flen = m.flen;
                        r.tlen = m.tlen;
                        r.text = m.to;
                    end
                end else begin
                    r.maybe = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

endpackage

// ===== design/ptmtn_in_if.sv =====
// Input channel of the pinyin tone converter: valid, ready, one text byte and its end flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface ptmtn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ===== design/ptmtn_out_if.sv =====
// Output channel of the pinyin tone converter: valid, ready and one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface ptmtn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

// ===== design/ptmtn_front.sv =====
// Front end of the pinyin tone converter: byte intake and table matching.
// Depends on ptmtn_pkg and ptmtn_in_if; feeds converted text to the queue.
`timescale 1ns / 1ps

module ptmtn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ptmtn_in_if.sink         i_in,
    input  logic             i_full,
    output logic             o_push,
    output ptmtn_pkg::t_tok  o_push_tok
);

    logic [23:0] r_pend;
    logic [1:0]  r_cnt;
    logic [23:0] n_pend;
    logic [1:0]  n_cnt;

    logic              fire;
    logic [2:0]        n_win;
    logic [31:0]       win;
    logic [31:0]       sub;
    logic [31:0]       rest;
    logic [2:0]        pos;
    logic [2:0]        rem;
    logic [2:0]        tcnt;
    logic [31:0]       text;
    logic              stop;
    ptmtn_pkg::t_match mr;

    assign i_in.ready = !i_full;
    assign fire       = i_in.valid && i_in.ready;

    // Window = pending prefix followed by the new byte, first byte at the top.
    always_comb begin
        n_win = {1'b0, r_cnt} + 3'd1;
        win   = {r_pend, 8'h00} | ({i_in.in_byte, 24'h000000} >> {r_cnt, 3'b000});
        pos   = 3'd0;
        tcnt  = 3'd0;
        text  = '0;
        stop  = 1'b0;
        sub   = win;
        rem   = n_win;
        mr    = '0;
        for (int s = 0; s < 4; s++) begin
            if (!stop && pos < n_win) begin
                sub = win << {pos, 3'b000};
                rem = n_win - pos;
                mr  = ptmtn_pkg::match_window(sub, rem);
                if (mr.hit) begin
                    text = text | ({mr.text, 8'h00} >> {tcnt, 3'b000});
                    pos  = pos + mr.flen;
                    tcnt = tcnt + {1'b0, mr.tlen};
                end else if (mr.maybe && !i_in.is_last) begin
                    // Still a possible entry: keep the rest for the next byte.
                    stop = 1'b1;
                end else begin
                    text = text | ({sub[31:24], 24'h000000} >> {tcnt, 3'b000});
                    pos  = pos + 3'd1;
                    tcnt = tcnt + 3'd1;
                end
            end
        end
        rest = win << {pos, 3'b000};
        if (i_in.is_last) begin
            n_pend = '0;
            n_cnt  = 2'd0;
        end else begin
            n_pend = rest[31:8];
            n_cnt  = 2'(n_win - pos);
        end
    end

    assign o_push          = fire && (tcnt != 3'd0 || i_in.is_last);
    assign o_push_tok.text = text;
    assign o_push_tok.cnt  = tcnt;
    assign o_push_tok.last = i_in.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= 2'd0;
        end else if (fire) begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== design/ptmtn_queue.sv =====
// Short register queue of converted-text transactions between front and back.
// Depends on ptmtn_pkg for the entry type.
`timescale 1ns / 1ps

module ptmtn_queue #(
    parameter int DEPTH = ptmtn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ptmtn_pkg::t_tok  i_push_tok,
    output logic             o_full,
    input  logic             i_pop,
    output ptmtn_pkg::t_tok  o_head,
    output logic             o_head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptmtn_pkg::t_tok  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/ptmtn_back.sv =====
// Back end of the pinyin tone converter: digit handling per tone mode, end
// marking and the output register. Depends on ptmtn_pkg and ptmtn_out_if.
`timescale 1ns / 1ps

module ptmtn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_tone_mode,
    input  ptmtn_pkg::t_tok  i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    ptmtn_out_if.source      o_out
);

    logic [2:0] r_idx;
    logic       r_produced;
    logic [7:0] r_held_digit;
    logic       r_held_valid;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_last;

    logic [2:0]  n_idx;
    logic        n_produced;
    logic [7:0]  n_held_digit;
    logic        n_held_valid;

    logic        out_free;
    logic        go;
    logic        at_end;
    logic        mode_strip;
    logic        mode_moved;
    logic [31:0] shifted;
    logic [7:0]  cur;
    logic        cur_digit;
    logic [7:0]  tb;
    logic        later_prod;
    logic        later_digit;
    logic        end_flush;
    logic        emit;
    logic        pop;
    logic [7:0]  e_byte;
    logic        e_has;
    logic        e_last;

    assign out_free   = !r_out_valid || o_out.ready;
    assign go         = i_head_valid && out_free;
    assign at_end     = (r_idx == i_head.cnt);
    assign mode_strip = (i_tone_mode == ptmtn_pkg::TONE_STRIP);
    assign mode_moved = (i_tone_mode == ptmtn_pkg::TONE_MOVED);
    assign shifted    = i_head.text << {r_idx[1:0], 3'b000};
    assign cur        = shifted[31:24];
    assign cur_digit  = ptmtn_pkg::is_digit(cur);

    // Whether a later text byte of this transaction will still give a result.
    always_comb begin
        later_prod  = 1'b0;
        later_digit = 1'b0;
        tb          = 8'h00;
        for (int j = 0; j < 4; j++) begin
            tb = i_head.text[31-8*j -: 8];
            if (3'(j) > r_idx && 3'(j) < i_head.cnt) begin
                if (!ptmtn_pkg::is_digit(tb) || (!mode_strip && !mode_moved)) begin
                    later_prod = 1'b1;
                end
                if (ptmtn_pkg::is_digit(tb)) begin
                    later_digit = 1'b1;
                end
            end
        end
    end

    always_comb begin
        emit         = 1'b0;
        pop          = 1'b0;
        e_byte       = cur;
        e_has        = 1'b1;
        e_last       = 1'b0;
        end_flush    = 1'b0;
        n_held_digit = r_held_digit;
        n_held_valid = r_held_valid;
        n_produced   = r_produced;
        n_idx        = r_idx + 3'd1;
        if (!at_end) begin
            if (!cur_digit) begin
                emit = 1'b1;
            end else if (mode_moved) begin
                emit         = r_held_valid;
                e_byte       = r_held_digit;
                n_held_digit = cur;
                n_held_valid = 1'b1;
            end else begin
                emit = !mode_strip;
            end
            n_produced = r_produced || emit;
            end_flush  = n_held_valid || (mode_moved && later_digit);
            e_last     = i_head.last && !later_prod && !end_flush;
            if (r_idx + 3'd1 == i_head.cnt &&
                !(i_head.last && (n_held_valid || !n_produced))) begin
                pop = 1'b1;
            end
        end else begin
            // End step: release a held digit or mark an empty string end.
            pop = 1'b1;
            if (i_head.last) begin
                e_last = 1'b1;
                if (r_held_valid) begin
                    emit   = 1'b1;
                    e_byte = r_held_digit;
                end else if (!r_produced) begin
                    emit   = 1'b1;
                    e_byte = 8'h00;
                    e_has  = 1'b0;
                end
                n_held_valid = 1'b0;
                n_held_digit = 8'h00;
            end
        end
        if (pop) begin
            n_idx      = 3'd0;
            n_produced = 1'b0;
        end
    end

    assign o_pop          = go && pop;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.has_byte = r_out_has;
    assign o_out.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= 3'd0;
            r_produced   <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (go) begin
                r_idx        <= n_idx;
                r_produced   <= n_produced;
                r_held_valid <= n_held_valid;
            end
            if (out_free) begin
                r_out_valid <= i_head_valid && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_held_digit <= n_held_digit;
        end
        if (go && emit) begin
            r_out_byte <= e_byte;
            r_out_has  <= e_has;
            r_out_last <= e_last;
        end
    end

endmodule

// ===== design/pinyin_tone_mark_to_number.sv =====
// Path: an accepted byte's converted text goes into the queue, then into the output register.
// Throughput: one input byte per cycle while the queue is not full. The back end walks
// the converted bytes of a transaction in turn and, on the last byte of a string, adds an
// end step when a held digit or a bare end marker has to go out; at most one result a cycle.
// Reset: i_rst_n is synchronous and active low; it empties the queue, drops pending bytes
// and any held digit, and sets tone_mode to numbered (1). No clearing pass.
`timescale 1ns / 1ps

// Converts tone-marked pinyin (UTF-8) into base letters with tone digits.
//
// The front end keeps up to three bytes that might still start a table entry.
// Each accepted byte is appended to them and the window is resolved at once:
// full table matches turn into their letter and digit, bytes that can no longer
// start an entry pass through unchanged, and a prefix that could still grow
// waits for the next byte. The last byte of a string resolves everything.
//
// The converted text of an input byte (up to four bytes) goes as one transaction
// into a short queue when there is any or the byte ends the string. The back end
// walks through it a byte at a time and treats digits according to tone_mode:
// drop them, keep them, or hold each one back until the next digit or the end
// of the string. It also puts out_last on the result that closes the string and
// sends a bare end marker when the last input byte gives nothing at all.
//
// The queue lets the front keep accepting while the back is still expanding a
// longer match or waiting on a stalled output.
module pinyin_tone_mark_to_number #(
    parameter int QUEUE_DEPTH = ptmtn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    ptmtn_in_if.sink    i_in,
    ptmtn_out_if.source o_out
);

    // Tone mode register; the user must write it only while the block is idle (not enforced).
    logic [1:0] r_tone_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_mode <= ptmtn_pkg::TONE_NUMBERED;
        end else if (i_cfg_we) begin
            r_tone_mode <= i_cfg_data;
        end
    end

    // Front to queue.
    logic            push;
    ptmtn_pkg::t_tok push_tok;
    logic            full;

    // Queue to back.
    ptmtn_pkg::t_tok head;
    logic            head_valid;
    logic            pop;

    ptmtn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_push_tok (push_tok)
    );

    ptmtn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_tok   (push_tok),
        .o_full       (full),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    // The back end reads the mode live. The user must write it only while nothing is in
    // flight (the block does not enforce this), which may still be in the middle of a string;
    // a held digit then stays held until a digit handled in moved mode or the end of the string.
    ptmtn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tone_mode  (r_tone_mode),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== design/ptmtn_checker.sv =====
// Port-level checker for the pinyin tone converter, bound to the top level.
// Depends on pinyin_tone_mark_to_number_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "pinyin_tone_mark_to_number_assert.svh"

module ptmtn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_has,
    input logic       i_last
);

    // A stalled result stays offered.
    `PTMTN_ASSERT_RST(a_out_valid_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid, "output valid dropped while stalled")

    // A stalled result keeps its payload.
    `PTMTN_ASSERT_RST(a_out_payload_hold, i_clk, i_rst_n, i_valid && !i_ready |=> $stable(i_byte) && $stable(i_has) && $stable(i_last), "output payload changed while stalled")

    // A result without a byte only ever closes a string and carries a zero byte.
    `PTMTN_ASSERT_RST(a_bare_marker, i_clk, i_rst_n, i_valid && !i_has |-> i_last && i_byte == 8'h00, "bare result is not a clean end marker")

    // Reset empties the output register.
    `PTMTN_ASSERT(a_reset_idle, i_clk, !i_rst_n |=> !i_valid, "output valid after reset")

endmodule

bind pinyin_tone_mark_to_number ptmtn_checker u_ptmtn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_has   (o_out.has_byte),
    .i_last  (o_out.out_last)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the pinyin tone-mark to tone-number converter.
// Depends on ptmtn_pkg, ptmtn_in_if, ptmtn_out_if and pinyin_tone_mark_to_number.
`timescale 1ns / 1ps

module testbench;

    // The fourth mode code has no name in the package; the block treats it as numbered.
    localparam logic [1:0] TONE_ALT_NUMBERED = 2'd3;
    // Cycles allowed after the last expected result before the block counts as idle,
    // so that a byte still held in the front end or dropped as a digit has settled.
    localparam int DRAIN_CYCLES = 8;
    // Bound on the final wait for outstanding results.
    localparam int FINAL_WAIT = 20000;

    // One result transaction as it appears on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_text_result;

    // The scoreboard converts each accepted input byte itself and keeps the results
    // that the block owes in order. Its state mirrors the block: the bytes that may
    // still begin a tone-marked letter, the digit held back in moved mode and the mode.
    class t_tone_scoreboard;
        logic [7:0]   mark_from[ptmtn_pkg::NUM_MARKS][4];
        int           mark_flen[ptmtn_pkg::NUM_MARKS];
        logic [7:0]   mark_txt[ptmtn_pkg::NUM_MARKS][3];
        int           mark_tlen[ptmtn_pkg::NUM_MARKS];
        int           n_marks;
        logic [1:0]   mode;
        logic [7:0]   pend[3];
        int           pend_cnt;
        logic [7:0]   held_digit;
        bit           held_valid;
        t_text_result due[$];
        int           mismatches;

        // Source bytes sit left-aligned in fr, replacement bytes left-aligned in txt.
        function void add_mark(int fl, logic [31:0] fr, int tl, logic [23:0] txt);
            for (int k = 0; k < 4; k++) mark_from[n_marks][k] = fr[31-8*k -: 8];
            for (int k = 0; k < 3; k++) mark_txt[n_marks][k] = txt[23-8*k -: 8];
            mark_flen[n_marks] = fl;
            mark_tlen[n_marks] = tl;
            n_marks++;
        endfunction

        function void add_pair(logic [15:0] cp, logic [7:0] letter, logic [7:0] digit);
            add_mark(2, {cp, 16'h0000}, 2, {letter, digit, 8'h00});
        endfunction

        function new();
            n_marks    = 0;
            mode       = ptmtn_pkg::TONE_NUMBERED;
            pend       = '{default: 8'h00};
            pend_cnt   = 0;
            held_digit = 8'h00;
            held_valid = 1'b0;
            mismatches = 0;
            add_pair(16'hC481, "a", "1"); add_pair(16'hC3A1, "a", "2");
            add_pair(16'hC78E, "a", "3"); add_pair(16'hC3A0, "a", "4");
            add_pair(16'hC493, "e", "1"); add_pair(16'hC3A9, "e", "2");
            add_pair(16'hC49B, "e", "3"); add_pair(16'hC3A8, "e", "4");
            add_pair(16'hC58D, "o", "1"); add_pair(16'hC3B3, "o", "2");
            add_pair(16'hC792, "o", "3"); add_pair(16'hC3B2, "o", "4");
            add_pair(16'hC4AB, "i", "1"); add_pair(16'hC3AD, "i", "2");
            add_pair(16'hC790, "i", "3"); add_pair(16'hC3AC, "i", "4");
            add_pair(16'hC5AB, "u", "1"); add_pair(16'hC3BA, "u", "2");
            add_pair(16'hC794, "u", "3"); add_pair(16'hC3B9, "u", "4");
            // u with diaeresis alone becomes a bare v without a digit.
            add_mark(2, 32'hC3BC_0000, 1, {"v", 16'h0000});
            add_pair(16'hC796, "v", "1"); add_pair(16'hC798, "v", "2");
            add_pair(16'hC79A, "v", "3"); add_pair(16'hC79C, "v", "4");
            add_pair(16'hC584, "n", "2"); add_pair(16'hC588, "n", "3");
            add_pair(16'hC7B9, "n", "4");
            add_mark(3, 32'h6DCC_8400, 2, {"m", "1", 8'h00});
            add_mark(3, 32'hE1B8_BF00, 2, {"m", "2", 8'h00});
            add_mark(3, 32'h6DCC_8000, 2, {"m", "4", 8'h00});
            // The e-circumflex letters keep their two UTF-8 bytes ahead of the digit.
            add_mark(4, 32'hC3AA_CC84, 3, {8'hC3, 8'hAA, "1"});
            add_mark(3, 32'hE1BA_BF00, 3, {8'hC3, 8'hAA, "2"});
            add_mark(4, 32'hC3AA_CC8C, 3, {8'hC3, 8'hAA, "3"});
            add_mark(3, 32'hE1BB_8100, 3, {8'hC3, 8'hAA, "4"});
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function void put_byte(logic [7:0] b);
            t_text_result r;
            r.out_byte = b;
            r.has_byte = 1'b1;
            r.out_last = 1'b0;
            due = {due, r};
        endfunction

        // Converted text goes through here: digits are dropped, kept or held back.
        function void put_text(logic [7:0] b);
            if (b < "0" || b > "9") begin
                put_byte(b);
            end else if (mode == ptmtn_pkg::TONE_STRIP) begin
                return;
            end else if (mode == ptmtn_pkg::TONE_MOVED) begin
                if (held_valid) put_byte(held_digit);
                held_digit = b;
                held_valid = 1'b1;
            end else begin
                put_byte(b);
            end
        endfunction

        // Works out the results of one accepted input byte.
        function void convert_byte(logic [7:0] b, bit ends);
            logic [7:0]   win[4];
            int           n;
            int           pos;
            int           rem;
            int           hit;
            int           first_new;
            bit           maybe;
            bit           eq;
            t_text_result marker;

            first_new = due.size();
            n = pend_cnt;
            for (int i = 0; i < n; i++) win[i] = pend[i];
            win[n] = b;
            n++;
            pos = 0;
            while (pos < n) begin
                rem   = n - pos;
                hit   = -1;
                maybe = 1'b0;
                for (int e = 0; e < n_marks && hit < 0; e++) begin
                    eq = 1'b1;
                    for (int k = 0; k < mark_flen[e] && k < rem; k++) begin
                        if (win[pos+k] != mark_from[e][k]) eq = 1'b0;
                    end
                    if (eq) begin
                        if (mark_flen[e] <= rem) hit = e;
                        else maybe = 1'b1;
                    end
                end
                if (hit >= 0) begin
                    for (int k = 0; k < mark_tlen[hit]; k++) put_text(mark_txt[hit][k]);
                    pos += mark_flen[hit];
                end else if (maybe && !ends) begin
                    // The window could still grow into a letter; wait for more bytes.
                    break;
                end else begin
                    put_text(win[pos]);
                    pos++;
                end
            end

            pend_cnt = n - pos;
            for (int i = 0; i < 3; i++) begin
                if (i < pend_cnt) pend[i] = win[pos+i];
                else pend[i] = 8'h00;
            end

            if (ends) begin
                if (held_valid) put_byte(held_digit);
                held_valid = 1'b0;
                held_digit = 8'h00;
                pend_cnt   = 0;
                pend       = '{default: 8'h00};
                if (due.size() == first_new) begin
                    marker.out_byte = 8'h00;
                    marker.has_byte = 1'b0;
                    marker.out_last = 1'b1;
                    due = {due, marker};
                end else begin
                    due[due.size()-1].out_last = 1'b1;
                end
            end
        endfunction

        function void report(string what, t_text_result want, t_text_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: %s: expected byte %02h has %0b last %0b, %s",
                         $time, what, want.out_byte, want.has_byte, want.out_last,
                         $sformatf("got byte %02h has %0b last %0b",
                                   got.out_byte, got.has_byte, got.out_last));
            end
        endfunction

        function void check_output(logic [7:0] ob, logic hb, logic ol);
            t_text_result want;
            t_text_result got;
            got.out_byte = ob;
            got.has_byte = hb;
            got.out_last = ol;
            if (due.size() == 0) begin
                want = '0;
                report("result with nothing outstanding", want, got);
                return;
            end
            want = due.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.out_last !== want.out_last) begin
                report("result mismatch", want, got);
            end
        endfunction

        function void flag_missing();
            t_text_result none;
            none = '0;
            while (due.size() != 0) report("result never arrived", due.pop_front(), none);
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = ptmtn_pkg::TONE_NUMBERED;

    ptmtn_in_if  in_ch ();
    ptmtn_out_if out_ch ();

    pinyin_tone_mark_to_number i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_tone_scoreboard board;

    // Idle rates in percent. The sender's rate is only read by the stimulus process;
    // the receiver's rate and the hold-off flag cross processes and change at edges.
    int src_idle_pct = 24;
    int snk_idle_pct = 70;
    bit hold_active  = 1'b0;

    always #5 i_clk = ~i_clk;

    // Receiver: a result transaction completes at an edge where valid and ready are
    // both high. Values read right after the edge are those the block presented before
    // it, so the check never depends on process ordering. Ready for the next cycle is
    // then chosen at random, or held low while a long hold-off is running.
    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            board.check_output(out_ch.out_byte, out_ch.has_byte, out_ch.out_last);
        end
        out_ch.ready <= !hold_active && ($urandom_range(99) >= snk_idle_pct);
    end

    // Run limit, far above the slowest passing run: about 230 input bytes with up to
    // five results each at a 70 % receiver stall, plus hold-offs and idle waits.
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct <= snk_pct;
    endtask

    // Offers one byte, with random idle cycles ahead of it, and returns at the edge at
    // which it is accepted. Valid is left high so that the next byte can follow at once.
    task automatic send_byte(input logic [7:0] b, input bit ends);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.is_last <= ends;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        board.convert_byte(b, ends);
    endtask

    // Sends len bytes held right-aligned in txt, first byte highest. When ends is set
    // the final byte closes the string.
    task automatic send_part(input logic [47:0] txt, input int len, input bit ends);
        for (int k = 0; k < len; k++) begin
            send_byte(txt[8*(len-1-k) +: 8], ends && (k == len - 1));
        end
    endtask

    // Lowers valid and waits until the block owes nothing and has settled.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The mode register is only written while the block is idle. The scoreboard takes
    // the new mode at the edge at which the block stores it.
    task automatic write_mode(input logic [1:0] m);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_mode(m);
    endtask

    task automatic hold_receiver(input int cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active <= 1'b0;
    endtask

    // Random strings built mostly from whole tone-marked letters, plain letters and
    // digits, so that the matcher and the digit handling see realistic text. Cut-off
    // letters and arbitrary bytes mixed in give broken sequences and noise, and a
    // string may end in the middle of a letter.
    task automatic random_phase(input int items);
        logic [7:0] txt[$];
        int         sent;
        int         pieces;
        int         kind;
        int         e;
        int         cut;
        sent = 0;
        while (sent < items) begin
            txt.delete();
            pieces = $urandom_range(6, 1);
            repeat (pieces) begin
                kind = $urandom_range(99);
                e    = $urandom_range(ptmtn_pkg::NUM_MARKS - 1);
                if (kind < 45) begin
                    for (int k = 0; k < board.mark_flen[e]; k++) begin
                        txt = {txt, board.mark_from[e][k]};
                    end
                end else if (kind < 65) begin
                    txt = {txt, 8'($urandom_range(8'h7A, 8'h61))};   // lower-case letter
                end else if (kind < 78) begin
                    txt = {txt, 8'($urandom_range(8'h39, 8'h30))};   // decimal digit
                end else if (kind < 88) begin
                    cut = $urandom_range(board.mark_flen[e] - 1, 1);
                    for (int k = 0; k < cut; k++) txt = {txt, board.mark_from[e][k]};
                end else begin
                    txt = {txt, 8'($urandom_range(255))};
                end
            end
            foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
            sent += txt.size();
        end
    endtask

    initial begin
        int spin;

        board = new();
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.is_last <= 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings in the reset mode (numbered), under the first idling pattern.
        send_part(48'hC481, 2, 1'b1);           // a with macron becomes a1
        send_part(48'h6DCC84, 3, 1'b1);         // m then combining macron: prefix waits
        send_part(48'hC3AACC8C, 4, 1'b1);       // e-circumflex with caron, four bytes
        send_part(48'hE1BB81, 3, 1'b1);         // three-byte e-circumflex with grave
        send_part(48'hC3BC, 2, 1'b1);           // u with diaeresis, no digit
        send_part(48'h6D78, 2, 1'b1);           // m that never becomes a letter
        send_part(48'hC3, 1, 1'b1);             // lone lead byte flushed by the end
        send_part(48'h00FF, 2, 1'b1);           // byte extremes pass through

        // Moved mode: the 2 of n2 is held and released by the literal 7, which is held
        // in turn. The mode then changes mid-string; in strip mode the 3 is dropped and
        // the held 7 still comes out at the end of the string.
        write_mode(ptmtn_pkg::TONE_MOVED);
        send_part(48'hC5843762, 4, 1'b0);
        write_mode(ptmtn_pkg::TONE_STRIP);
        send_part(48'h337A, 2, 1'b1);
        // A string that is only a dropped digit ends in a bare end marker.
        send_part(48'h39, 1, 1'b1);

        write_mode(ptmtn_pkg::TONE_MOVED);
        random_phase(60);

        write_mode(TONE_ALT_NUMBERED);
        set_idling(70, 24);
        random_phase(50);

        // No idling from here on. First the receiver holds off for a long stretch while
        // the sender keeps offering bytes, so that the queue fills and input stalls.
        write_mode(ptmtn_pkg::TONE_STRIP);
        set_idling(0, 0);
        fork
            hold_receiver(120);
            random_phase(25);
        join
        random_phase(25);

        write_mode(ptmtn_pkg::TONE_NUMBERED);
        random_phase(25);

        in_ch.valid <= 1'b0;
        spin = 0;
        while (board.due.size() != 0 && spin < FINAL_WAIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.flag_missing();

        if (board.mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ptmtn_pkg.sv
design/ptmtn_in_if.sv
design/ptmtn_out_if.sv
design/ptmtn_front.sv
design/ptmtn_queue.sv
design/ptmtn_back.sv
design/pinyin_tone_mark_to_number.sv
design/ptmtn_checker.sv
tb/testbench.sv
